// File: hw/rtl/jtpd_pkg.sv
// Package with shared types, constants and register codes for the jagged locator.
package jtpd_pkg;

  localparam int DEF_MAX_LEVELS  = 5;
  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_OFFSET_BITS = 32;

  localparam int NUM_SIZE_REGS = 5;
  localparam int SIZE_W        = 16;
  localparam int LCNT_W        = 3;
  localparam int APB_AW        = 5;
  localparam int APB_DW        = 32;

  localparam logic [2:0] REG_NUM_LEVELS   = 3'd0;
  localparam logic [2:0] REG_LEVEL_SIZE_0 = 3'd1;
  localparam logic [2:0] REG_LEVEL_SIZE_4 = 3'd5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  level;
    logic [11:0] entry_index;
    logic [31:0] entry_value;
    logic [11:0] outer_index;
    logic [31:0] flat_jagged_index;
  } req_t;

  typedef struct packed {
    logic [31:0] source_row;
    logic        is_padding;
    logic        range_error;
  } rsp_t;

  typedef struct packed {
    logic [LCNT_W-1:0]                   levels;
    logic [NUM_SIZE_REGS-1:0][SIZE_W-1:0] size;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_RD_END,
    ST_CMP,
    ST_FINISH
  } state_t;

endpackage

// File: hw/rtl/jtpd_regs.sv
// APB configuration registers for level count and level sizes.
module jtpd_regs #(
  parameter int MAX_LEVELS = jtpd_pkg::DEF_MAX_LEVELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jtpd_pkg::APB_AW-1:0] paddr,
  input  logic [jtpd_pkg::APB_DW-1:0] pwdata,
  output logic [jtpd_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output jtpd_pkg::cfg_t              cfg
);
  import jtpd_pkg::*;

  logic [2:0]        num_levels;
  logic [SIZE_W-1:0] level_size [NUM_SIZE_REGS];
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_levels <= 3'd1;
      for (int k = 0; k < NUM_SIZE_REGS; k++) begin
        level_size[k] <= SIZE_W'(1);
      end
    end else if (wr_en) begin
      if (reg_idx == REG_NUM_LEVELS) begin
        num_levels <= pwdata[2:0];
      end else if (reg_idx >= REG_LEVEL_SIZE_0 && reg_idx <= REG_LEVEL_SIZE_4) begin
        level_size[reg_idx - REG_LEVEL_SIZE_0] <= pwdata[SIZE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_NUM_LEVELS) begin
      prdata = APB_DW'(num_levels);
    end else if (reg_idx >= REG_LEVEL_SIZE_0 && reg_idx <= REG_LEVEL_SIZE_4) begin
      prdata = APB_DW'(level_size[reg_idx - REG_LEVEL_SIZE_0]);
    end
  end

  always_comb begin
    if (num_levels == 3'd0) begin
      cfg.levels = LCNT_W'(1);
    end else if (32'(num_levels) > 32'(MAX_LEVELS)) begin
      cfg.levels = LCNT_W'(MAX_LEVELS);
    end else begin
      cfg.levels = num_levels;
    end
    for (int k = 0; k < NUM_SIZE_REGS; k++) begin
      cfg.size[k] = (level_size[k] == '0) ? SIZE_W'(1) : level_size[k];
    end
  end

endmodule

// File: hw/rtl/jtpd_divider.sv
// Restoring radix-2 divider of a 32-bit index by a 16-bit level size.
module jtpd_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [31:0]                 dividend,
  input  logic [jtpd_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [31:0]                 quotient,
  output logic [jtpd_pkg::SIZE_W-1:0] remainder
);
  import jtpd_pkg::*;

  logic              busy;
  logic [4:0]        cnt;
  logic [31:0]       quo;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dvsr;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   trial;
  logic              fits;

  assign shifted = {rem, quo[31]};
  assign trial   = shifted - {1'b0, dvsr};
  assign fits    = shifted >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quo <= {quo[30:0], fits};
      rem <= fits ? trial[SIZE_W-1:0] : shifted[SIZE_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: hw/rtl/jtpd_table_mem.sv
// Offset table memory for all levels with one write and one registered read port.
module jtpd_table_mem #(
  parameter int DEPTH  = jtpd_pkg::DEF_MAX_LEVELS * jtpd_pkg::DEF_TABLE_DEPTH,
  parameter int DATA_W = jtpd_pkg::DEF_OFFSET_BITS,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/jagged_to_padded_dense_locator.sv
// Top level: request sequencer around the shared divider and the offset table memory.
// A write request is taken only while idle and gives no response.
// A query runs one serial division per level in use, then for each level walked a range
// check, two table reads and a compare, and finally loads the response.
// Requests are taken one at a time, only while idle; the divider gives one quotient bit per cycle.
// Reset returns control state, rsp_valid and config to defaults; the offset tables are undefined until written.
module jagged_to_padded_dense_locator #(
  parameter int MAX_LEVELS  = jtpd_pkg::DEF_MAX_LEVELS,
  parameter int TABLE_DEPTH = jtpd_pkg::DEF_TABLE_DEPTH,
  parameter int OFFSET_BITS = jtpd_pkg::DEF_OFFSET_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  jtpd_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output jtpd_pkg::rsp_t              rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jtpd_pkg::APB_AW-1:0] paddr,
  input  logic [jtpd_pkg::APB_DW-1:0] pwdata,
  output logic [jtpd_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import jtpd_pkg::*;

  localparam int MEM_DEPTH = MAX_LEVELS * TABLE_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int WORK_W    = (OFFSET_BITS < 64) ? OFFSET_BITS + 1 : 64;

  cfg_t cfg;

  state_t                           state, state_next;
  logic [LCNT_W-1:0]                d, d_next;
  logic [WORK_W-1:0]                offset, offset_next;
  logic [OFFSET_BITS-1:0]           begin_val, begin_val_next;
  logic [MAX_LEVELS-1:0][SIZE_W-1:0] coords, coords_next;
  rsp_t                             res, res_next;
  rsp_t                             rsp_reg;
  logic                             rsp_load;

  logic              div_start;
  logic [31:0]       div_dividend;
  logic [SIZE_W-1:0] div_divisor;
  logic              div_done;
  logic [31:0]       div_quo;
  logic [SIZE_W-1:0] div_rem;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic                   mem_re;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [OFFSET_BITS-1:0] mem_rdata;
  logic [OFFSET_BITS-1:0] wr_value;

  logic              req_acc;
  logic [31:0]       entry_ext;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] rd_base;
  logic [63:0]       offset_ext;
  logic [OFFSET_BITS-1:0] span;
  logic [OFFSET_BITS-1:0] coord_ext;

  jtpd_regs #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jtpd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  jtpd_table_mem #(
    .DEPTH  (MEM_DEPTH),
    .DATA_W (OFFSET_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req_stall = (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;

  assign entry_ext = 32'(req.entry_index);
  assign wr_idx    = entry_ext[IDX_W-1:0];
  assign wr_value  = OFFSET_BITS'(req.entry_value);
  assign mem_we    = req_acc && (req.cmd == CMD_WRITE) &&
                     (32'(req.level) < 32'(MAX_LEVELS)) &&
                     (entry_ext < 32'(TABLE_DEPTH));
  assign mem_waddr = ADDR_W'(req.level) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(wr_idx);

  assign offset_ext = 64'(offset);
  assign rd_base    = ADDR_W'(d) * ADDR_W'(TABLE_DEPTH);
  assign mem_raddr  = rd_base + ADDR_W'(rd_idx);
  assign span       = mem_rdata - begin_val;
  assign coord_ext  = OFFSET_BITS'(coords[d[LVL_W-1:0]]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      d     <= '0;
    end else begin
      state <= state_next;
      d     <= d_next;
    end
  end

  always_ff @(posedge clk) begin
    offset    <= offset_next;
    begin_val <= begin_val_next;
    coords    <= coords_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    d_next         = d;
    offset_next    = offset;
    begin_val_next = begin_val;
    coords_next    = coords;
    res_next       = res;
    div_start      = 1'b0;
    div_dividend   = div_quo;
    div_divisor    = cfg.size[d];
    mem_re         = 1'b0;
    rd_idx         = offset[IDX_W-1:0];
    rsp_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_acc && req.cmd == CMD_QUERY) begin
          d_next       = cfg.levels - LCNT_W'(1);
          offset_next  = WORK_W'(req.outer_index);
          div_start    = 1'b1;
          div_dividend = req.flat_jagged_index;
          div_divisor  = cfg.size[cfg.levels - LCNT_W'(1)];
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          coords_next[d[LVL_W-1:0]] = div_rem;
          if (d == '0) begin
            state_next = ST_CHECK;
          end else begin
            d_next      = d - LCNT_W'(1);
            div_start   = 1'b1;
            div_divisor = cfg.size[d - LCNT_W'(1)];
          end
        end
      end
      ST_CHECK: begin
        if (offset_ext >= 64'(TABLE_DEPTH - 1)) begin
          res_next   = '{source_row: '0, is_padding: 1'b0, range_error: 1'b1};
          state_next = ST_FINISH;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_RD_END;
        end
      end
      ST_RD_END: begin
        begin_val_next = mem_rdata;
        rd_idx         = offset[IDX_W-1:0] + IDX_W'(1);
        mem_re         = 1'b1;
        state_next     = ST_CMP;
      end
      ST_CMP: begin
        if (mem_rdata <= begin_val || coord_ext >= span) begin
          res_next   = '{source_row: '0, is_padding: 1'b1, range_error: 1'b0};
          state_next = ST_FINISH;
        end else begin
          offset_next = WORK_W'(begin_val) + WORK_W'(coords[d[LVL_W-1:0]]);
          if (d == cfg.levels - LCNT_W'(1)) begin
            res_next   = '{source_row: '0, is_padding: 1'b0, range_error: 1'b0};
            state_next = ST_FINISH;
          end else begin
            d_next     = d + LCNT_W'(1);
            state_next = ST_CHECK;
          end
        end
      end
      ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_reg <= '{source_row: (!res.is_padding && !res.range_error) ? offset_ext[31:0] : '0,
                   is_padding: res.is_padding,
                   range_error: res.range_error};
    end
  end

  assign rsp = rsp_reg;

endmodule
